/* design/skrt_pkg.sv */
`default_nettype none

package skrt_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int KEY_W = 24;
	localparam int VAL_W = 32;
	localparam int COUNT_OUT_W = 8;

	typedef enum logic [1:0] {
		REQ_INSERT    = 2'd0,
		REQ_SEARCH    = 2'd1,
		REQ_ADD_QTY   = 2'd2,
		REQ_ADD_PRICE = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_DUP     = 2'd2,
		STAT_MISSING = 2'd3
	} status_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SCAN,
		ST_DONE
	} state_e_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] qty;
		logic [VAL_W-1:0] prc;
	} rec_t;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] qty;
		logic [VAL_W-1:0] prc;
	} tok_t;

	typedef struct packed {
		logic             cmp;
		logic             ins;
		logic             wr_qty;
		logic             wr_prc;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] qty;
		logic [VAL_W-1:0] prc;
	} cmd_t;

endpackage

`default_nettype wire

/* design/sorted_keyed_record_table.sv */
// Sorted record table built as a row of CAPACITY cells, one record per cell, kept in
// ascending key order. One request is handled at a time: it is taken when the block is
// idle, and the next one is not taken until its result word has been registered. The
// lookup word walks the cell row one cell per cycle to carry the matching record to the
// end of the row. An insert then shifts all larger records up one cell at once, and an
// add writes the saturated sum back into the matching cell. If the previous result word
// has not yet been taken, the block holds the finished result until the output register
// frees up.
`default_nettype none

module sorted_keyed_record_table #(
	parameter int CAPACITY = skrt_pkg::CAPACITY_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    req_type,
	input  wire logic [skrt_pkg::KEY_W-1:0]    part_key,
	input  wire logic signed [skrt_pkg::VAL_W-1:0] quantity_value,
	input  wire logic signed [skrt_pkg::VAL_W-1:0] price_value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         status,
	output logic signed [skrt_pkg::VAL_W-1:0]  found_quantity,
	output logic signed [skrt_pkg::VAL_W-1:0]  found_price,
	output logic [skrt_pkg::COUNT_OUT_W-1:0]   entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SC_W  = $clog2(CAPACITY);
	localparam int VW    = skrt_pkg::VAL_W;

	skrt_pkg::state_e_t  state_q, state_d;
	skrt_pkg::req_e_t    req_q;
	logic [skrt_pkg::KEY_W-1:0] key_q;
	logic [VW-1:0]       qv_q, pv_q;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [SC_W-1:0]     scan_q;
	skrt_pkg::cmd_t      cmd;

	logic                out_valid_q;
	skrt_pkg::status_e_t status_q, status_d;
	logic [VW-1:0]       oqty_q, oqty_d, oprc_q, oprc_d;
	logic [skrt_pkg::COUNT_OUT_W-1:0] ocnt_q;
	logic [CNT_W+skrt_pkg::COUNT_OUT_W-1:0] cnt_ext;

	skrt_pkg::rec_t      rec_w [CAPACITY];
	logic                keep_w [CAPACITY];
	skrt_pkg::tok_t      tok_w [CAPACITY];
	skrt_pkg::tok_t      tok_end;

	logic                accept, fire_done, full, ins_ok;
	logic [VW-1:0]       add_a, add_b, sat_sum;
	logic [VW:0]         add_s;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != skrt_pkg::ST_IDLE;
	assign fire_done = (state_q == skrt_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign tok_end   = tok_w[CAPACITY-1];
	assign full      = count_q >= CNT_W'(CAPACITY);
	assign ins_ok    = (req_q == skrt_pkg::REQ_INSERT) && !full && !tok_end.found;

	assign add_a   = (req_q == skrt_pkg::REQ_ADD_PRICE) ? tok_end.prc : tok_end.qty;
	assign add_b   = (req_q == skrt_pkg::REQ_ADD_PRICE) ? pv_q : qv_q;
	assign add_s   = {add_a[VW-1], add_a} + {add_b[VW-1], add_b};
	assign sat_sum = (add_s[VW] != add_s[VW-1]) ?
		(add_s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}}) : add_s[VW-1:0];

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		status_d = skrt_pkg::STAT_OK;
		oqty_d   = '0;
		oprc_d   = '0;
		cmd      = '{cmp: 1'b0, ins: 1'b0, wr_qty: 1'b0, wr_prc: 1'b0,
			key: key_q, qty: qv_q, prc: pv_q};
		unique case (state_q)
			skrt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = skrt_pkg::ST_CMP;
				end
			end
			skrt_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = skrt_pkg::ST_SCAN;
			end
			skrt_pkg::ST_SCAN: begin
				if (scan_q == SC_W'(CAPACITY - 1)) begin
					state_d = skrt_pkg::ST_DONE;
				end
			end
			skrt_pkg::ST_DONE: begin
				priority if (req_q == skrt_pkg::REQ_INSERT) begin
					priority if (full) begin
						status_d = skrt_pkg::STAT_FULL;
					end else if (tok_end.found) begin
						status_d = skrt_pkg::STAT_DUP;
					end else begin
						cmd.ins = fire_done;
						count_d = count_q + CNT_W'(1);
						oqty_d  = qv_q;
						oprc_d  = pv_q;
					end
				end else if (!tok_end.found) begin
					status_d = skrt_pkg::STAT_MISSING;
				end else begin
					oqty_d = tok_end.qty;
					oprc_d = tok_end.prc;
					if (req_q == skrt_pkg::REQ_ADD_QTY) begin
						oqty_d     = sat_sum;
						cmd.qty    = sat_sum;
						cmd.wr_qty = fire_done;
					end
					if (req_q == skrt_pkg::REQ_ADD_PRICE) begin
						oprc_d     = sat_sum;
						cmd.prc    = sat_sum;
						cmd.wr_prc = fire_done;
					end
				end
				if (fire_done) begin
					state_d = skrt_pkg::ST_IDLE;
				end
			end
			default: state_d = skrt_pkg::ST_IDLE;
		endcase
	end

	assign cnt_ext = {{skrt_pkg::COUNT_OUT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skrt_pkg::ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == skrt_pkg::ST_SCAN) begin
				scan_q <= scan_q + SC_W'(1);
			end else begin
				scan_q <= '0;
			end
			if (fire_done) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= skrt_pkg::req_e_t'(req_type);
			key_q <= part_key;
			qv_q  <= quantity_value;
			pv_q  <= price_value;
		end
		if (fire_done) begin
			status_q <= status_d;
			oqty_q   <= oqty_d;
			oprc_q   <= oprc_d;
			ocnt_q   <= cnt_ext[skrt_pkg::COUNT_OUT_W-1:0];
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			skrt_cell #(.CNT_W(CNT_W), .INDEX(i)) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.count     (count_q),
				.prev_rec  ('0),
				.prev_keep (1'b1),
				.tok_in    ('0),
				.rec       (rec_w[i]),
				.keep      (keep_w[i]),
				.tok_out   (tok_w[i])
			);
		end else begin : g_body
			skrt_cell #(.CNT_W(CNT_W), .INDEX(i)) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.count     (count_q),
				.prev_rec  (rec_w[i-1]),
				.prev_keep (keep_w[i-1]),
				.tok_in    (tok_w[i-1]),
				.rec       (rec_w[i]),
				.keep      (keep_w[i]),
				.tok_out   (tok_w[i])
			);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_quantity = oqty_q;
	assign found_price    = oprc_q;
	assign entry_count    = ocnt_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("record count exceeds capacity");

	a_accept_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == skrt_pkg::ST_CMP)
		else $error("accepted request did not start a compare");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_done && ins_ok) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("successful insert did not grow the table");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire_done && ins_ok) |=> $stable(count_q))
		else $error("record count changed without an insert");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == skrt_pkg::ST_DONE))
		else $error("result word appeared outside the finish step");
`endif

endmodule

`default_nettype wire

/* design/skrt_cell.sv */
`default_nettype none

module skrt_cell #(
	parameter int CNT_W = 8,
	parameter int INDEX = 0
) (
	input  wire logic              clk,
	input  wire skrt_pkg::cmd_t    cmd,
	input  wire logic [CNT_W-1:0]  count,
	input  wire skrt_pkg::rec_t    prev_rec,
	input  wire logic              prev_keep,
	input  wire skrt_pkg::tok_t    tok_in,
	output skrt_pkg::rec_t         rec,
	output logic                   keep,
	output skrt_pkg::tok_t         tok_out
);

	skrt_pkg::rec_t rec_q;
	skrt_pkg::tok_t tok_q;
	logic           keep_q;
	logic           eq_q;
	logic           occ;

	assign occ = count > CNT_W'(INDEX);

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			eq_q   <= occ && (rec_q.key == cmd.key);
			keep_q <= occ && (rec_q.key < cmd.key);
		end
		if (cmd.ins && !keep_q) begin
			if (prev_keep) begin
				rec_q <= '{key: cmd.key, qty: cmd.qty, prc: cmd.prc};
			end else begin
				rec_q <= prev_rec;
			end
		end
		if (cmd.wr_qty && eq_q) begin
			rec_q.qty <= cmd.qty;
		end
		if (cmd.wr_prc && eq_q) begin
			rec_q.prc <= cmd.prc;
		end
		if (!tok_in.found && eq_q) begin
			tok_q <= '{found: 1'b1, qty: rec_q.qty, prc: rec_q.prc};
		end else begin
			tok_q <= tok_in;
		end
	end

	assign rec     = rec_q;
	assign keep    = keep_q;
	assign tok_out = tok_q;

endmodule

`default_nettype wire

/* tb/tb_sorted_keyed_record_table.sv */
`default_nettype none

module tb_sorted_keyed_record_table;
	timeunit 1ns;
	timeprecision 1ps;

	import skrt_pkg::*;

	localparam int TABLE_DEPTH = CAPACITY_DEF;
	localparam int RANDOM_WORDS = 430;

	typedef struct packed {
		status_e_t   st;
		logic [31:0] qty;
		logic [31:0] prc;
		logic [7:0]  cnt;
	} table_reply_t;

	typedef struct packed {
		req_e_t       req;
		logic [23:0]  key;
		logic [31:0]  qv;
		logic [31:0]  pv;
		logic         typed;
		table_reply_t reply;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = 2'd0;
	logic [23:0] part_key = 24'd0;
	logic signed [31:0] quantity_value = 32'sd0;
	logic signed [31:0] price_value = 32'sd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [31:0] found_quantity;
	logic signed [31:0] found_price;
	logic [7:0] entry_count;

	logic [23:0] held_keys [TABLE_DEPTH];
	logic signed [31:0] held_qty [TABLE_DEPTH];
	logic signed [31:0] held_prc [TABLE_DEPTH];
	int held_count = 0;

	table_reply_t replies_due [$];
	int bad_replies = 0;
	int words_sent = 0;
	int stall_left = 0;
	logic calm = 1'b0;
	logic hold_off = 1'b0;

	sorted_keyed_record_table #(
		.CAPACITY(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.part_key(part_key),
		.quantity_value(quantity_value),
		.price_value(price_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found_quantity(found_quantity),
		.found_price(found_price),
		.entry_count(entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int find_slot(logic [23:0] key);
		for (int i = 0; i < held_count; i++)
			if (held_keys[i] == key)
				return i;
		return -1;
	endfunction

	function automatic logic signed [31:0] sat_sum(logic signed [31:0] a, logic signed [31:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (s < -64'sd2147483648)
			return 32'sh80000000;
		return s[31:0];
	endfunction

	function automatic table_reply_t apply_request(req_e_t req, logic [23:0] key,
			logic [31:0] qv, logic [31:0] pv);
		table_reply_t r;
		int slot;
		int pos;
		r = '{STAT_OK, 32'h0, 32'h0, 8'h0};
		if (req == REQ_INSERT) begin
			if (held_count >= TABLE_DEPTH) begin
				r.st = STAT_FULL;
			end else if (find_slot(key) >= 0) begin
				r.st = STAT_DUP;
			end else begin
				pos = 0;
				while (pos < held_count && held_keys[pos] < key)
					pos++;
				for (int j = held_count; j > pos; j--) begin
					held_keys[j] = held_keys[j-1];
					held_qty[j] = held_qty[j-1];
					held_prc[j] = held_prc[j-1];
				end
				held_keys[pos] = key;
				held_qty[pos] = qv;
				held_prc[pos] = pv;
				held_count++;
				r.qty = qv;
				r.prc = pv;
			end
		end else begin
			slot = find_slot(key);
			if (slot < 0) begin
				r.st = STAT_MISSING;
			end else begin
				if (req == REQ_ADD_QTY)
					held_qty[slot] = sat_sum(held_qty[slot], qv);
				else if (req == REQ_ADD_PRICE)
					held_prc[slot] = sat_sum(held_prc[slot], pv);
				r.qty = held_qty[slot];
				r.prc = held_prc[slot];
			end
		end
		r.cnt = held_count[7:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 24);
		return $urandom_range(60, 260);
	endfunction

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom;
		if (r < 70)
			return $urandom_range(0, 2000) - 1000;
		if (r < 85)
			return 32'h7FFFFFFF - $urandom_range(0, 50);
		return 32'h80000000 + $urandom_range(0, 50);
	endfunction

	function automatic logic [23:0] pick_present_key();
		if (held_count == 0)
			return 24'($urandom);
		return held_keys[$urandom_range(0, held_count - 1)];
	endfunction

	function automatic logic [23:0] pick_absent_key();
		logic [23:0] k;
		do
			k = 24'($urandom_range(0, 24'hFFFFFF));
		while (find_slot(k) >= 0);
		return k;
	endfunction

	task automatic send_word(input req_e_t req, input logic [23:0] key, input logic [31:0] qv,
			input logic [31:0] pv, input logic typed, input table_reply_t fixed);
		table_reply_t due;
		int gap;
		in_valid <= 1'b1;
		req_type <= req;
		part_key <= key;
		quantity_value <= qv;
		price_value <= pv;
		do
			@(posedge clk);
		while (in_stall);
		due = apply_request(req, key, qv, pv);
		replies_due.push_back(typed ? fixed : due);
		words_sent++;
		gap = (calm || hold_off) ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_reply();
		table_reply_t due;
		if (replies_due.size() == 0) begin
			bad_replies++;
			if (bad_replies <= 10)
				$display("unexpected result word: status %0d qty %0d price %0d count %0d",
					status, found_quantity, found_price, entry_count);
			return;
		end
		due = replies_due.pop_front();
		if (status !== due.st || found_quantity !== due.qty || found_price !== due.prc ||
				entry_count !== due.cnt) begin
			bad_replies++;
			if (bad_replies <= 10)
				$display("mismatch: exp st %0d q %0d p %0d n %0d, got st %0d q %0d p %0d n %0d",
					due.st, $signed(due.qty), $signed(due.prc), due.cnt,
					status, found_quantity, found_price, entry_count);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_reply();
			if (stall_left != 0)
				stall_left--;
			else if (!calm && $urandom_range(0, 7) == 0)
				stall_left = pick_gap();
			out_stall <= hold_off || stall_left != 0;
		end
	end

	// The receiver holds off long enough for the block to fill and stall its input.
	initial begin
		wait (words_sent >= 60);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (1500) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		stim_row_t directed_rows [$];
		stim_row_t row;
		req_e_t req;
		logic [23:0] key;
		int r;

		directed_rows.push_back(stim_row_t'{REQ_SEARCH, 24'h000000, 32'h0, 32'h0, 1'b1,
			'{STAT_MISSING, 32'h0, 32'h0, 8'd0}});
		directed_rows.push_back(stim_row_t'{REQ_ADD_QTY, 24'h000005, 32'h1, 32'h0, 1'b1,
			'{STAT_MISSING, 32'h0, 32'h0, 8'd0}});
		directed_rows.push_back(stim_row_t'{REQ_ADD_PRICE, 24'hFFFFFF, 32'h0, 32'h7FFFFFFF, 1'b1,
			'{STAT_MISSING, 32'h0, 32'h0, 8'd0}});
		directed_rows.push_back(stim_row_t'{REQ_INSERT, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			1'b1, '{STAT_OK, 32'h7FFFFFFF, 32'h80000000, 8'd1}});
		directed_rows.push_back(stim_row_t'{REQ_INSERT, 24'h000000, 32'h80000000, 32'h7FFFFFFF,
			1'b1, '{STAT_OK, 32'h80000000, 32'h7FFFFFFF, 8'd2}});
		directed_rows.push_back(stim_row_t'{REQ_INSERT, 24'hFFFFFF, 32'h1, 32'h1, 1'b1,
			'{STAT_DUP, 32'h0, 32'h0, 8'd2}});
		directed_rows.push_back(stim_row_t'{REQ_ADD_QTY, 24'hFFFFFF, 32'h1, 32'h0, 1'b1,
			'{STAT_OK, 32'h7FFFFFFF, 32'h80000000, 8'd2}});
		directed_rows.push_back(stim_row_t'{REQ_ADD_PRICE, 24'hFFFFFF, 32'h0, 32'hFFFFFFFF, 1'b1,
			'{STAT_OK, 32'h7FFFFFFF, 32'h80000000, 8'd2}});
		directed_rows.push_back(stim_row_t'{REQ_ADD_QTY, 24'h000000, 32'hFFFFFFFF, 32'h0, 1'b1,
			'{STAT_OK, 32'h80000000, 32'h7FFFFFFF, 8'd2}});
		directed_rows.push_back(stim_row_t'{REQ_ADD_PRICE, 24'h000000, 32'h0, 32'h7FFFFFFF, 1'b1,
			'{STAT_OK, 32'h80000000, 32'h7FFFFFFF, 8'd2}});
		directed_rows.push_back(stim_row_t'{REQ_ADD_QTY, 24'hFFFFFF, 32'h80000000, 32'h0, 1'b1,
			'{STAT_OK, 32'hFFFFFFFF, 32'h80000000, 8'd2}});
		directed_rows.push_back(stim_row_t'{REQ_INSERT, 24'h800000, 32'h0, 32'h0, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{REQ_INSERT, 24'h7FFFFF, 32'h55555555, 32'hAAAAAAAA,
			1'b0, '0});
		directed_rows.push_back(stim_row_t'{REQ_INSERT, 24'h000001, 32'hAAAAAAAA, 32'h55555555,
			1'b0, '0});
		directed_rows.push_back(stim_row_t'{REQ_SEARCH, 24'h800000, 32'hFFFFFFFF, 32'hFFFFFFFF,
			1'b0, '0});
		directed_rows.push_back(stim_row_t'{REQ_ADD_QTY, 24'h7FFFFF, 32'h7FFFFFFF, 32'h0, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{REQ_ADD_PRICE, 24'h7FFFFF, 32'h0, 32'h80000000,
			1'b0, '0});
		directed_rows.push_back(stim_row_t'{REQ_SEARCH, 24'h123456, 32'h0, 32'h0, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{REQ_ADD_PRICE, 24'h000001, 32'h0, 32'h00000064,
			1'b0, '0});
		directed_rows.push_back(stim_row_t'{REQ_SEARCH, 24'hFFFFFF, 32'h0, 32'h0, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{REQ_INSERT, 24'h000002, 32'h0, 32'h0, 1'b0, '0});
		directed_rows.push_back(stim_row_t'{REQ_SEARCH, 24'h000000, 32'h0, 32'h0, 1'b0, '0});

		wait (arst_n);
		@(posedge clk);
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_word(row.req, row.key, row.qv, row.pv, row.typed, row.reply);
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			calm <= (n >= 150 && n < 190);
			r = $urandom_range(0, 99);
			if (r < 55) begin
				req = REQ_INSERT;
				key = pick_absent_key();
			end else if (r < 62) begin
				req = REQ_INSERT;
				key = pick_present_key();
			end else if (r < 75) begin
				req = REQ_SEARCH;
				key = pick_present_key();
			end else if (r < 81) begin
				req = REQ_SEARCH;
				key = pick_absent_key();
			end else if (r < 89) begin
				req = REQ_ADD_QTY;
				key = pick_present_key();
			end else if (r < 96) begin
				req = REQ_ADD_PRICE;
				key = pick_present_key();
			end else begin
				req = ($urandom_range(0, 1) == 0) ? REQ_ADD_QTY : REQ_ADD_PRICE;
				key = pick_absent_key();
			end
			send_word(req, key, pick_value(), pick_value(), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (bad_replies == 0 && replies_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
